FILE: hdl/marker_length_frame_extractor_unit_defines.svh
// assertion helpers used by the deframer result queue
`ifndef MARKER_LENGTH_FRAME_EXTRACTOR_UNIT_DEFINES_SVH
`define MARKER_LENGTH_FRAME_EXTRACTOR_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define MLFE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define MLFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mlfe_pkg.sv
package mlfe_pkg;

  localparam int BYTE_W   = 8;
  localparam int DLEN_W   = 11;
  localparam int PLEN_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FIRST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SECOND   = 2'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] END_FIRST_RST    = 8'd85;
  localparam logic [BYTE_W-1:0] END_SECOND_RST   = 8'd170;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_END1,
    PH_END2
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_NO_START,
    VERDICT_BAD_LENGTH,
    VERDICT_BAD_END
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_VERDICT
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   payload_byte;
    verdict_t            verdict;
    logic                verdict_last;
  } res_t;

endpackage

FILE: hdl/mlfe_ifs.sv
// byte channel into the deframer
interface mlfe_in_if;
  logic                              valid;
  logic                              ready;
  logic [mlfe_pkg::BYTE_W-1:0]       data_byte;
  logic                              first_of_datagram;
  logic                              last_of_datagram;
  logic [mlfe_pkg::DLEN_W-1:0]       datagram_length;

  modport source (output valid, data_byte, first_of_datagram, last_of_datagram,
                  datagram_length, input ready);
  modport sink (input valid, data_byte, first_of_datagram, last_of_datagram,
                datagram_length, output ready);
endinterface

// result channel out of the deframer
interface mlfe_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic [mlfe_pkg::BYTE_W-1:0]       payload_byte;
  logic [1:0]                        verdict;
  logic                              verdict_last;

  modport source (output valid, result_kind, payload_byte, verdict, verdict_last,
                  input ready);
  modport sink (input valid, result_kind, payload_byte, verdict, verdict_last,
                output ready);
endinterface

FILE: hdl/marker_length_frame_extractor_unit.sv
// Start/length/end marker deframer: takes one datagram byte per cycle and, when no
// backpressure is present, accepts a byte in every cycle; each byte yields at most one
// result, a payload byte or the frame verdict. The edge that takes the byte writes the
// result into the result queue, and from there it moves into the output register that
// drives the result port. The decode stage holds the marker search state and stalls
// only when its two-entry result queue is full; the output register absorbs consumer
// stalls.
// No clearing pass follows reset. The user writes marker registers through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce this.
module marker_length_frame_extractor_unit #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mlfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfe_pkg::BYTE_W-1:0]      cfg_data,
  mlfe_in_if.sink                          data,
  mlfe_out_if.source                       result
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  mlfe_pkg::res_t  push_res, pop_res;

  // byte decode and marker search
  mlfe_front #(
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data       (data),
    .push_valid (push_valid),
    .push_res   (push_res),
    .push_ready (push_ready)
  );

  // result queue between decode and output
  mlfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_res   (push_res),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_res    (pop_res),
    .pop_ready  (pop_ready)
  );

  // registered result port
  mlfe_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_res   (pop_res),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

FILE: hdl/mlfe_front.sv
module mlfe_front #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mlfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlfe_pkg::BYTE_W-1:0]          cfg_data,
  mlfe_in_if.sink                              data,
  output logic                                 push_valid,
  output mlfe_pkg::res_t                       push_res,
  input  logic                                 push_ready
);

  localparam int PW = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam int SW = ((PW > mlfe_pkg::PLEN_W) ? PW : mlfe_pkg::PLEN_W) + 2;

  mlfe_pkg::phase_t phase, phase_next, eff_phase;
  logic [PW-1:0] pos, pos_next, eff_pos;
  logic [mlfe_pkg::BYTE_W-1:0] prev, prev_next, eff_prev;
  logic [mlfe_pkg::BYTE_W-1:0] len_lo, len_lo_next;
  logic [mlfe_pkg::PLEN_W-1:0] rem, rem_next, rem_dec, len_word;
  logic done, done_next, eff_done;
  logic [mlfe_pkg::BYTE_W-1:0] start_first, start_second, end_first, end_second;
  logic [SW-1:0] dlen_x, sum_end, sum_hunt;
  logic len_bad, hunt_hit, step_fin, accept, res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= mlfe_pkg::START_FIRST_RST;
      start_second <= mlfe_pkg::START_SECOND_RST;
      end_first    <= mlfe_pkg::END_FIRST_RST;
      end_second   <= mlfe_pkg::END_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlfe_pkg::CFG_START_FIRST:  start_first  <= cfg_data;
        mlfe_pkg::CFG_START_SECOND: start_second <= cfg_data;
        mlfe_pkg::CFG_END_FIRST:    end_first    <= cfg_data;
        mlfe_pkg::CFG_END_SECOND:   end_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = data.valid && data.ready;
  assign data.ready = push_ready;

  // state as seen by this byte, after a datagram restart
  assign eff_phase = data.first_of_datagram ? mlfe_pkg::PH_HUNT : phase;
  assign eff_pos   = data.first_of_datagram ? '0 : pos;
  assign eff_prev  = data.first_of_datagram ? '0 : prev;
  assign eff_done  = data.first_of_datagram ? 1'b0 : done;

  // length and marker checks
  assign len_word = {data.data_byte, len_lo};
  assign dlen_x   = SW'(data.datagram_length);
  assign sum_end  = SW'(eff_pos) + SW'(len_word) + SW'(3);
  assign sum_hunt = SW'(eff_pos) + SW'(2);
  assign len_bad  = (len_word == '0) || (SW'(len_word) > dlen_x) || (sum_end > dlen_x);
  assign hunt_hit = (eff_pos != '0) && (eff_prev == start_first) &&
                    (data.data_byte == start_second) && (sum_hunt <= dlen_x);
  assign rem_dec  = (rem == '0) ? rem : rem - 1'b1;
  assign step_fin = !eff_done &&
                    (((eff_phase == mlfe_pkg::PH_LEN_HI) && len_bad) ||
                     (eff_phase == mlfe_pkg::PH_END2));

  // next phase
  always_comb begin
    phase_next = eff_phase;
    if (!eff_done) begin
      unique case (eff_phase)
        mlfe_pkg::PH_HUNT:    phase_next = hunt_hit ? mlfe_pkg::PH_LEN_LO : mlfe_pkg::PH_HUNT;
        mlfe_pkg::PH_LEN_LO:  phase_next = mlfe_pkg::PH_LEN_HI;
        mlfe_pkg::PH_LEN_HI:  phase_next = len_bad ? mlfe_pkg::PH_LEN_HI
                                                   : mlfe_pkg::PH_PAYLOAD;
        mlfe_pkg::PH_PAYLOAD: phase_next = (rem_dec == '0) ? mlfe_pkg::PH_END1
                                                           : mlfe_pkg::PH_PAYLOAD;
        mlfe_pkg::PH_END1:    phase_next = mlfe_pkg::PH_END2;
        mlfe_pkg::PH_END2:    phase_next = mlfe_pkg::PH_END2;
        default:              phase_next = mlfe_pkg::PH_HUNT;
      endcase
    end
  end

  // result for this byte
  always_comb begin
    res_valid              = 1'b0;
    push_res.kind          = mlfe_pkg::KIND_PAYLOAD;
    push_res.payload_byte  = '0;
    push_res.verdict       = mlfe_pkg::VERDICT_OK;
    push_res.verdict_last  = 1'b0;
    if (step_fin) begin
      res_valid             = 1'b1;
      push_res.kind         = mlfe_pkg::KIND_VERDICT;
      push_res.verdict_last = 1'b1;
      if (eff_phase == mlfe_pkg::PH_LEN_HI) begin
        push_res.verdict = mlfe_pkg::VERDICT_BAD_LENGTH;
      end else if ((eff_prev == end_first) && (data.data_byte == end_second)) begin
        push_res.verdict = mlfe_pkg::VERDICT_OK;
      end else begin
        push_res.verdict = mlfe_pkg::VERDICT_BAD_END;
      end
    end else if (!eff_done && data.last_of_datagram) begin
      // datagram ends before the frame does
      res_valid             = 1'b1;
      push_res.kind         = mlfe_pkg::KIND_VERDICT;
      push_res.verdict_last = 1'b1;
      push_res.verdict      = (phase_next == mlfe_pkg::PH_HUNT) ?
                              mlfe_pkg::VERDICT_NO_START : mlfe_pkg::VERDICT_BAD_LENGTH;
    end else if (!eff_done && (eff_phase == mlfe_pkg::PH_PAYLOAD)) begin
      res_valid             = 1'b1;
      push_res.payload_byte = data.data_byte;
    end
  end

  assign push_valid = data.valid && res_valid;

  // other state updates
  always_comb begin
    done_next   = eff_done || step_fin || data.last_of_datagram;
    pos_next    = (eff_pos < PW'(MAX_DATAGRAM_BYTES)) ? eff_pos + 1'b1 : eff_pos;
    prev_next   = eff_prev;
    len_lo_next = len_lo;
    rem_next    = rem;
    if (!eff_done) begin
      unique case (eff_phase)
        mlfe_pkg::PH_HUNT:    prev_next = data.data_byte;
        mlfe_pkg::PH_END1:    prev_next = data.data_byte;
        mlfe_pkg::PH_LEN_LO:  len_lo_next = data.data_byte;
        mlfe_pkg::PH_LEN_HI:  rem_next = len_bad ? rem : len_word;
        mlfe_pkg::PH_PAYLOAD: rem_next = rem_dec;
        default: ;
      endcase
    end
  end

  // state registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= mlfe_pkg::PH_HUNT;
      pos    <= '0;
      prev   <= '0;
      len_lo <= '0;
      rem    <= '0;
      done   <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      prev   <= prev_next;
      len_lo <= len_lo_next;
      rem    <= rem_next;
      done   <= done_next;
    end
  end

endmodule

FILE: hdl/mlfe_queue.sv
`include "marker_length_frame_extractor_unit_defines.svh"

module mlfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  mlfe_pkg::res_t    push_res,
  output logic              push_ready,
  output logic              pop_valid,
  output mlfe_pkg::res_t    pop_res,
  input  logic              pop_ready
);

  localparam int AW = $clog2(mlfe_pkg::QDEPTH);
  localparam int CW = $clog2(mlfe_pkg::QDEPTH + 1);

  mlfe_pkg::res_t    mem [mlfe_pkg::QDEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              push, pop;

  assign push_ready = (count != CW'(mlfe_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_res    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MLFE_ASSERT_ALWAYS(a_count_range, count <= CW'(mlfe_pkg::QDEPTH), "queue overfilled")
  `MLFE_ASSERT_NEXT(a_count_inc, push && !pop, count == $past(count) + 1'b1, "bad count on push")
  `MLFE_ASSERT_NEXT(a_count_dec, pop && !push, count == $past(count) - 1'b1, "bad count on pop")

endmodule

FILE: hdl/mlfe_out_stage.sv
module mlfe_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  mlfe_pkg::res_t    pop_res,
  output logic              pop_ready,
  mlfe_out_if.source        result
);

  logic            out_valid;
  mlfe_pkg::res_t  out_res;
  logic            load;

  assign pop_ready = !out_valid || result.ready;
  assign load      = pop_valid && pop_ready;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= pop_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_kind  = out_res.kind;
  assign result.payload_byte = out_res.payload_byte;
  assign result.verdict      = out_res.verdict;
  assign result.verdict_last = out_res.verdict_last;

endmodule

FILE: sim/deframer_checker.sv
`timescale 1ns / 1ps

// watches both channels of the deframer, predicts every result and compares
module deframer_checker #(
  parameter int MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mlfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfe_pkg::BYTE_W-1:0]    cfg_data,
  mlfe_in_if                             data,
  mlfe_out_if                            result,
  output int                             mismatch_count,
  output int                             results_due
);

  // marker registers as the block should hold them
  logic [mlfe_pkg::BYTE_W-1:0] start_first_q, start_second_q, end_first_q, end_second_q;

  // search state of the deframer
  mlfe_pkg::phase_t            phase_q;
  logic [mlfe_pkg::DLEN_W-1:0] position_q;
  logic [mlfe_pkg::BYTE_W-1:0] prior_byte_q;
  logic [mlfe_pkg::BYTE_W-1:0] length_low_q;
  logic [mlfe_pkg::PLEN_W-1:0] remaining_q;
  logic                        finished_q;

  mlfe_pkg::res_t frame_results[$];

  // advance the search by one byte, returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [mlfe_pkg::BYTE_W-1:0] b,
                                      input logic first_flag, input logic last_flag,
                                      input logic [mlfe_pkg::DLEN_W-1:0] dlen,
                                      output mlfe_pkg::res_t r);
    int unsigned p;
    logic [mlfe_pkg::PLEN_W-1:0] len;
    bit emit;
    r = '0;
    r.kind = mlfe_pkg::KIND_PAYLOAD;
    r.verdict = mlfe_pkg::VERDICT_OK;
    emit = 1'b0;
    if (first_flag) begin
      phase_q = mlfe_pkg::PH_HUNT;
      position_q = '0;
      prior_byte_q = '0;
      finished_q = 1'b0;
    end
    if (!finished_q) begin
      p = 32'(position_q);
      case (phase_q)
        mlfe_pkg::PH_LEN_LO: begin
          length_low_q = b;
          phase_q = mlfe_pkg::PH_LEN_HI;
        end
        mlfe_pkg::PH_LEN_HI: begin
          len = {b, length_low_q};
          if (len == 0 || len > dlen || p + len + 3 > dlen) begin
            emit = 1'b1;
            r.kind = mlfe_pkg::KIND_VERDICT;
            r.verdict = mlfe_pkg::VERDICT_BAD_LENGTH;
            finished_q = 1'b1;
          end else begin
            remaining_q = len;
            phase_q = mlfe_pkg::PH_PAYLOAD;
          end
        end
        mlfe_pkg::PH_PAYLOAD: begin
          emit = 1'b1;
          r.payload_byte = b;
          if (remaining_q != 0) remaining_q--;
          if (remaining_q == 0) phase_q = mlfe_pkg::PH_END1;
        end
        mlfe_pkg::PH_END1: begin
          prior_byte_q = b;
          phase_q = mlfe_pkg::PH_END2;
        end
        mlfe_pkg::PH_END2: begin
          emit = 1'b1;
          r.kind = mlfe_pkg::KIND_VERDICT;
          r.verdict = (prior_byte_q == end_first_q && b == end_second_q) ?
                      mlfe_pkg::VERDICT_OK : mlfe_pkg::VERDICT_BAD_END;
          finished_q = 1'b1;
        end
        default: begin
          // a start marker needs its first byte inside the same datagram
          phase_q = mlfe_pkg::PH_HUNT;
          if (p >= 1 && prior_byte_q == start_first_q && b == start_second_q &&
              p + 2 <= dlen)
            phase_q = mlfe_pkg::PH_LEN_LO;
          prior_byte_q = b;
        end
      endcase
      // datagram ends before a verdict: the verdict replaces any payload byte
      if (last_flag && !finished_q) begin
        emit = 1'b1;
        r.kind = mlfe_pkg::KIND_VERDICT;
        r.payload_byte = '0;
        r.verdict = (phase_q == mlfe_pkg::PH_HUNT) ? mlfe_pkg::VERDICT_NO_START
                                                   : mlfe_pkg::VERDICT_BAD_LENGTH;
        finished_q = 1'b1;
      end
    end
    if (position_q < MAX_DATAGRAM_BYTES) position_q++;
    r.verdict_last = (r.kind == mlfe_pkg::KIND_VERDICT);
    return emit;
  endfunction

  // compare result requests, then predict from byte requests
  always @(posedge clk) begin
    mlfe_pkg::res_t want;
    mlfe_pkg::res_t due;
    if (rst) begin
      start_first_q  = mlfe_pkg::START_FIRST_RST;
      start_second_q = mlfe_pkg::START_SECOND_RST;
      end_first_q    = mlfe_pkg::END_FIRST_RST;
      end_second_q   = mlfe_pkg::END_SECOND_RST;
      phase_q        = mlfe_pkg::PH_HUNT;
      position_q     = '0;
      prior_byte_q   = '0;
      length_low_q   = '0;
      remaining_q    = '0;
      finished_q     = 1'b0;
      frame_results.delete();
      mismatch_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (frame_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result kind %0d byte %02h verdict %0d last %0d",
                     $time, result.result_kind, result.payload_byte, result.verdict,
                     result.verdict_last);
          mismatch_count++;
        end else begin
          want = frame_results.pop_front();
          if (result.result_kind !== want.kind || result.payload_byte !== want.payload_byte ||
              result.verdict !== want.verdict || result.verdict_last !== want.verdict_last)
          begin
            if (mismatch_count < 10)
              $display("%0t: mismatch exp k%0d b%02h v%0d l%0d got k%0d b%02h v%0d l%0d",
                       $time, want.kind, want.payload_byte, want.verdict, want.verdict_last,
                       result.result_kind, result.payload_byte, result.verdict,
                       result.verdict_last);
            mismatch_count++;
          end
        end
      end
      if (data.valid && data.ready) begin
        if (deframe_byte(data.data_byte, data.first_of_datagram, data.last_of_datagram,
                         data.datagram_length, due))
          frame_results.push_back(due);
      end
      // marker register writes
      if (cfg_we) begin
        case (cfg_index)
          mlfe_pkg::CFG_START_FIRST:  start_first_q  = cfg_data;
          mlfe_pkg::CFG_START_SECOND: start_second_q = cfg_data;
          mlfe_pkg::CFG_END_FIRST:    end_first_q    = cfg_data;
          mlfe_pkg::CFG_END_SECOND:   end_second_q   = cfg_data;
          default: ;
        endcase
      end
    end
    results_due <= frame_results.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_BYTES    = 1024;
  localparam int ITEM_TARGET  = 1350;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [mlfe_pkg::BYTE_W-1:0] octet_t;
  typedef logic [mlfe_pkg::DLEN_W-1:0] dlen_t;

  typedef struct {
    octet_t b;
    bit     first_flag;
    bit     last_flag;
    dlen_t  dlen;
  } dgram_byte_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [mlfe_pkg::CFG_IDX_W-1:0] cfg_index;
  octet_t                         cfg_data;
  int                             mismatch_count;
  int                             results_due;
  int                             items_sent;
  int                             quiet_cycles;
  bit                             calm;

  // marker values currently loaded, used to build frames
  octet_t sm_first, sm_second, em_first, em_second;

  dgram_byte_t outgoing[$];

  mlfe_in_if  data_ch ();
  mlfe_out_if result_ch ();

  marker_length_frame_extractor_unit #(.MAX_DATAGRAM_BYTES(MAX_BYTES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data      (data_ch),
    .result    (result_ch)
  );

  deframer_checker #(.MAX_DATAGRAM_BYTES(MAX_BYTES)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data           (data_ch),
    .result         (result_ch),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, one long hold-off while bytes keep coming
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // watchdog on cycles with no request on either channel
  always @(posedge clk) begin
    if (rst || (data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("marker_length_frame_extractor_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_byte(input octet_t b, input bit first_flag,
                          input bit last_flag, input dlen_t dlen);
    dgram_byte_t e;
    e.b = b;
    e.first_flag = first_flag;
    e.last_flag = last_flag;
    e.dlen = dlen;
    outgoing.push_back(e);
  endtask

  // offer one byte request, with random idle cycles ahead of it
  task automatic send_byte(input dgram_byte_t e);
    calm = (items_sent >= 700 && items_sent < 860);
    while (!calm && $urandom_range(99) < 13) begin
      data_ch.valid <= 1'b0;
      @(posedge clk);
    end
    data_ch.valid             <= 1'b1;
    data_ch.data_byte         <= e.b;
    data_ch.first_of_datagram <= e.first_flag;
    data_ch.last_of_datagram  <= e.last_flag;
    data_ch.datagram_length   <= e.dlen;
    @(posedge clk);
    while (!data_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_datagram();
    foreach (outgoing[i]) send_byte(outgoing[i]);
    outgoing.delete();
  endtask

  // let the block empty out before touching the registers
  task automatic settle();
    data_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(input octet_t a, input octet_t b,
                               input octet_t c, input octet_t d);
    cfg_we <= 1'b1;
    cfg_index <= mlfe_pkg::CFG_START_FIRST;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= mlfe_pkg::CFG_START_SECOND;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= mlfe_pkg::CFG_END_FIRST;
    cfg_data <= c;
    @(posedge clk);
    cfg_index <= mlfe_pkg::CFG_END_SECOND;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sm_first = a;
    sm_second = b;
    em_first = c;
    em_second = d;
  endtask

  // one random datagram: mostly frames, some damaged, some noise, some with a late start marker
  task automatic build_datagram();
    octet_t raw[$];
    octet_t pick;
    dlen_t dlen;
    int mode, junk, plen, tail, cut, damage, total;
    bit no_first, noisy;
    no_first = 1'b0;
    noisy = 1'b0;
    mode = $urandom_range(99);
    if (mode < 65) begin
      junk = $urandom_range(3);
      plen = ($urandom_range(19) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 12);
      tail = $urandom_range(2);
      repeat (junk) raw.push_back(octet_t'($urandom_range(255)));
      raw.push_back(sm_first);
      raw.push_back(sm_second);
      raw.push_back(plen[7:0]);
      raw.push_back(plen[15:8]);
      repeat (plen) raw.push_back(octet_t'($urandom_range(255)));
      raw.push_back(em_first);
      raw.push_back(em_second);
      repeat (tail) raw.push_back(octet_t'($urandom_range(255)));
      total = raw.size();
      dlen = dlen_t'(total);
      damage = $urandom_range(11);
      case (damage)
        0: raw[junk + 4 + plen + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        1: raw[junk + 2] = octet_t'($urandom_range(255));
        2: raw[junk + 3] = octet_t'($urandom_range(255));
        3: begin
          // datagram ends early, length field still names the full frame
          cut = $urandom_range(1, total - 1);
          while (raw.size() > cut) raw.pop_back();
        end
        4: dlen = ($urandom_range(1) != 0) ? dlen_t'(MAX_BYTES)
                                           : dlen_t'($urandom_range(1, MAX_BYTES - 1));
        5: no_first = 1'b1;
        default: ;
      endcase
    end else if (mode < 90) begin
      noisy = 1'b1;
      total = $urandom_range(1, 24);
      repeat (total) begin
        case ($urandom_range(9))
          0: pick = sm_first;
          1: pick = sm_second;
          2: pick = em_first;
          3: pick = ($urandom_range(1) != 0) ? 8'h00 : 8'hFF;
          default: pick = octet_t'($urandom_range(255));
        endcase
        raw.push_back(pick);
      end
      dlen = ($urandom_range(3) == 0) ? dlen_t'($urandom_range(1, MAX_BYTES))
                                      : dlen_t'(total);
    end else begin
      // start marker close to the end of the datagram
      repeat ($urandom_range(3)) raw.push_back(octet_t'($urandom_range(255)));
      raw.push_back(sm_first);
      raw.push_back(sm_second);
      repeat ($urandom_range(2)) raw.push_back(octet_t'($urandom_range(255)));
      dlen = dlen_t'(raw.size());
    end
    foreach (raw[i]) begin
      if (noisy && i > 0 && $urandom_range(9) == 0)
        add_byte(raw[i], $urandom_range(19) == 0, $urandom_range(19) == 0,
                 dlen_t'($urandom_range(1, MAX_BYTES)));
      else
        add_byte(raw[i], i == 0 && !no_first, i == raw.size() - 1, dlen);
    end
  endtask

  task automatic run_random(input int stop_at);
    while (items_sent < stop_at) begin
      build_datagram();
      send_datagram();
    end
  endtask

  // stimulus and verdict
  initial begin
    items_sent = 0;
    calm = 1'b0;
    sm_first = mlfe_pkg::START_FIRST_RST;
    sm_second = mlfe_pkg::START_SECOND_RST;
    em_first = mlfe_pkg::END_FIRST_RST;
    em_second = mlfe_pkg::END_SECOND_RST;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= mlfe_pkg::CFG_START_FIRST;
    cfg_data <= '0;
    data_ch.valid <= 1'b0;
    data_ch.data_byte <= '0;
    data_ch.first_of_datagram <= 1'b0;
    data_ch.last_of_datagram <= 1'b0;
    data_ch.datagram_length <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // good frame with no first flag right after reset
    add_byte(sm_first, 1'b0, 1'b0, 11'd7);
    add_byte(sm_second, 1'b0, 1'b0, 11'd7);
    add_byte(8'h01, 1'b0, 1'b0, 11'd7);
    add_byte(8'h00, 1'b0, 1'b0, 11'd7);
    add_byte(8'h42, 1'b0, 1'b0, 11'd7);
    add_byte(em_first, 1'b0, 1'b0, 11'd7);
    add_byte(em_second, 1'b0, 1'b1, 11'd7);
    // zero length, bytes after the verdict are dropped
    add_byte(sm_first, 1'b1, 1'b0, 11'd6);
    add_byte(sm_second, 1'b0, 1'b0, 11'd6);
    add_byte(8'h00, 1'b0, 1'b0, 11'd6);
    add_byte(8'h00, 1'b0, 1'b0, 11'd6);
    add_byte(8'hFF, 1'b0, 1'b0, 11'd6);
    add_byte(8'h00, 1'b0, 1'b1, 11'd6);
    // single byte datagram with the largest length field
    add_byte(8'hFF, 1'b1, 1'b1, dlen_t'(MAX_BYTES));
    // wrong end marker
    add_byte(sm_first, 1'b1, 1'b0, 11'd8);
    add_byte(sm_second, 1'b0, 1'b0, 11'd8);
    add_byte(8'h02, 1'b0, 1'b0, 11'd8);
    add_byte(8'h00, 1'b0, 1'b0, 11'd8);
    add_byte(8'h00, 1'b0, 1'b0, 11'd8);
    add_byte(8'hFF, 1'b0, 1'b0, 11'd8);
    add_byte(em_first, 1'b0, 1'b0, 11'd8);
    add_byte(8'h00, 1'b0, 1'b1, 11'd8);
    send_datagram();
    run_random(340);

    // all-zero markers: a match on the very first byte must not count
    settle();
    write_markers(8'h00, 8'h00, 8'h00, 8'h00);
    add_byte(8'h00, 1'b1, 1'b0, 11'd4);
    add_byte(8'h07, 1'b0, 1'b0, 11'd4);
    add_byte(8'h08, 1'b0, 1'b0, 11'd4);
    add_byte(8'h09, 1'b0, 1'b1, 11'd4);
    send_datagram();
    run_random(680);

    settle();
    write_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(1020);

    settle();
    write_markers(octet_t'($urandom_range(255)), octet_t'($urandom_range(255)),
                  octet_t'($urandom_range(255)), octet_t'($urandom_range(255)));
    run_random(ITEM_TARGET);

    settle();
    if (mismatch_count == 0) begin
      $display("marker_length_frame_extractor_unit test passed");
    end else begin
      $display("marker_length_frame_extractor_unit test failed");
    end
    $finish;
  end

endmodule
